### hw/rtl/deq_pkg.sv
// Package for the double-ended queue: request and response types, function and status codes.
package deq_pkg;

   // Request function codes
   localparam logic [2:0] FUNC_PUSH_BACK  = 3'd0;
   localparam logic [2:0] FUNC_POP_BACK   = 3'd1;
   localparam logic [2:0] FUNC_PUSH_FRONT = 3'd2;
   localparam logic [2:0] FUNC_POP_FRONT  = 3'd3;
   localparam logic [2:0] FUNC_DUMP       = 3'd4;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] item;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

endpackage

### hw/rtl/deq_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module deq_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/double_ended_queue.sv
// Bounded double-ended queue of 32-bit words kept in a RAM ring.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_type  (func, value)
//   rsp_      out        rsp_valid/rsp_ready  rsp_type  (item, status, last)
//
// A push, or a pop or dump that finds the queue empty, answers in the cycle after it
// is taken. A pop first reads the RAM, then loads the response. A dump makes one
// RAM read per entry, from the front, and flags the final response with last.
// Reset clears the pointers and the count; the RAM is not cleared.
// A stalled response holds the block; during a dump the RAM read address is held.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_POS = IW'(DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_DUMP
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] rpos_ff, rpos_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          slot_free;
   logic          accept;
   logic          is_full;
   logic          is_empty;
   logic          dump_last;
   logic [IW:0]   back_sum;
   logic [IW:0]   back_sum_m1;
   logic [IW-1:0] back_pos;
   logic [IW-1:0] tail_pos;
   logic [IW-1:0] front_dec;
   logic [IW-1:0] front_inc;
   logic [IW-1:0] rpos_inc;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [31:0]   rd_data;

   deq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (32)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_addr (rpos_in),
      .rd_data (rd_data)
   );

   // Handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Ring position arithmetic
   always_comb begin
      is_full     = (count_ff == FULL_CNT);
      is_empty    = (count_ff == '0);
      back_sum    = {1'b0, front_ff} + (IW + 1)'(count_ff);
      back_sum_m1 = back_sum - (IW + 1)'(1);
      back_pos    = (back_sum >= DEPTH_W) ? IW'(back_sum - DEPTH_W) : back_sum[IW-1:0];
      tail_pos    = (back_sum_m1 >= DEPTH_W) ? IW'(back_sum_m1 - DEPTH_W)
                                             : back_sum_m1[IW-1:0];
      front_dec   = (front_ff == '0) ? LAST_POS : front_ff - IW'(1);
      front_inc   = (front_ff == LAST_POS) ? '0 : front_ff + IW'(1);
      rpos_inc    = (rpos_ff == LAST_POS) ? '0 : rpos_ff + IW'(1);
      dump_last   = (idx_ff == IW'(count_ff - CW'(1)));
   end

   // Request sequencing
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      rpos_in      = rpos_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = back_pos;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
                     rsp_valid_in     = 1'b1;
                     rsp_data_in.item = '0;
                     rsp_data_in.last = 1'b1;
                     if (is_full) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        rsp_data_in.status = STATUS_OK;
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (req_data.func == FUNC_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                     end
                  end
                  FUNC_POP_BACK, FUNC_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{item: '0, status: STATUS_EMPTY, last: 1'b1};
                     end else begin
                        count_in = count_ff - CW'(1);
                        state_in = S_POP;
                        if (req_data.func == FUNC_POP_BACK) begin
                           rpos_in = tail_pos;
                        end else begin
                           rpos_in  = front_ff;
                           front_in = front_inc;
                        end
                     end
                  end
                  FUNC_DUMP: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{item: '0, status: STATUS_EMPTY, last: 1'b1};
                     end else begin
                        rpos_in  = front_ff;
                        idx_in   = '0;
                        state_in = S_DUMP;
                     end
                  end
                  default: begin
                     // unused codes give no response
                  end
               endcase
            end
         end
         S_POP: begin
            // read data for the popped entry is ready now
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{item: rd_data, status: STATUS_OK, last: 1'b1};
            state_in     = S_IDLE;
         end
         S_DUMP: begin
            // rd_data holds the entry at rpos_ff; advance only when the slot frees
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{item: rd_data, status: STATUS_OK, last: dump_last};
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  rpos_in = rpos_inc;
                  idx_in  = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rpos_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rpos_ff      <= rpos_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
